[sv/lse_pkg.sv]
// Shared types and constants for the LSB stego extractor.
// Used by the channel interfaces and by every module of the block.
package lse_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned MAGIC_W = 16;
    localparam int unsigned KIND_W  = 2;

    localparam logic [BYTE_W-1:0]  HEADER_RESET = 8'd54;
    localparam logic [MAGIC_W-1:0] MAGIC_RESET  = 16'd8998;
    localparam logic [CNT_W-1:0]   CHAR_BITS    = 5'd8;

    typedef enum logic [0:0] {
        CFG_HEADER_BYTES = 1'b0,
        CFG_MAGIC_WORD   = 1'b1
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_EXT_CHAR  = 2'd0,
        KIND_DATA_BYTE = 2'd1,
        KIND_BAD_MAGIC = 2'd2,
        KIND_EMPTY     = 2'd3
    } t_kind;

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_MAGIC   = 7'b0000010,
        PH_EXTLEN  = 7'b0000100,
        PH_EXTDATA = 7'b0001000,
        PH_FILELEN = 7'b0010000,
        PH_DATA    = 7'b0100000,
        PH_DONE    = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] image_byte;
        logic              image_start;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] secret_byte;
        t_kind             result_kind;
        logic              last_byte;
    } t_result;

    typedef struct packed {
        logic [BYTE_W-1:0]  header_bytes;
        logic [MAGIC_W-1:0] magic_word;
    } t_cfg;

endpackage

[sv/lse_if.sv]
// Valid/ready channel interfaces for image bytes and decoded results.
// Depends on lse_pkg for the field widths.
interface lse_in_if;
    import lse_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] image_byte;
    logic              image_start;
    modport source (output valid, output image_byte, output image_start, input ready);
    modport sink   (input valid, input image_byte, input image_start, output ready);
endinterface

interface lse_out_if;
    import lse_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] secret_byte;
    logic [KIND_W-1:0] result_kind;
    logic              last_byte;
    modport source (output valid, output secret_byte, output result_kind, output last_byte,
                    input ready);
    modport sink   (input valid, input secret_byte, input result_kind, input last_byte,
                    output ready);
endinterface

[sv/lse_in_stage.sv]
// Input register that holds one accepted image byte until the parser takes it.
// Depends on lse_pkg.
module lse_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  lse_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_take,
    output logic           o_valid,
    output lse_pkg::t_item o_item
);
    import lse_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end
endmodule

[sv/lse_parser.sv]
// Parse state and the per-byte step: header skip, magic check, lengths, characters.
// Depends on lse_pkg.
module lse_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  lse_pkg::t_item   i_item,
    input  lse_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output lse_pkg::t_result o_res
);
    import lse_pkg::*;

    t_phase              r_phase, n_phase, c_phase;
    logic [BYTE_W-1:0]   r_hdr_cnt, n_hdr_cnt, c_hdr_cnt;
    logic [CNT_W-1:0]    r_bit_cnt, n_bit_cnt, c_bit_cnt;
    logic [WORD_W-1:0]   r_shift, n_shift, c_shift;
    logic                r_magic_idx, n_magic_idx, c_magic_idx;
    logic                r_magic_ok, n_magic_ok, c_magic_ok;
    logic [WORD_W-1:0]   r_ext_left, n_ext_left, c_ext_left;
    logic [WORD_W-1:0]   r_data_left, n_data_left, c_data_left;

    logic [WORD_W-1:0]   g_shift;
    logic [CNT_W-1:0]    g_cnt;
    logic                done8;
    logic                done32;
    logic                in_header;
    logic                take_magic;
    logic [BYTE_W-1:0]   want;
    logic                match_ok;
    logic [WORD_W-1:0]   ext_dec;
    logic [WORD_W-1:0]   data_dec;

    always_comb begin
        if (i_item.image_start) begin
            c_phase     = PH_HEADER;
            c_hdr_cnt   = '0;
            c_bit_cnt   = '0;
            c_shift     = '0;
            c_magic_idx = 1'b0;
            c_magic_ok  = 1'b1;
            c_ext_left  = '0;
            c_data_left = '0;
        end else begin
            c_phase     = r_phase;
            c_hdr_cnt   = r_hdr_cnt;
            c_bit_cnt   = r_bit_cnt;
            c_shift     = r_shift;
            c_magic_idx = r_magic_idx;
            c_magic_ok  = r_magic_ok;
            c_ext_left  = r_ext_left;
            c_data_left = r_data_left;
        end
    end

    assign g_shift    = {c_shift[WORD_W-2:0], i_item.image_byte[0]};
    assign g_cnt      = c_bit_cnt + 1'b1;
    assign done8      = (g_cnt == CHAR_BITS);
    assign done32     = (g_cnt == '0);
    assign in_header  = (c_phase == PH_HEADER) && (c_hdr_cnt < i_cfg.header_bytes);
    assign take_magic = (c_phase == PH_MAGIC) || ((c_phase == PH_HEADER) && !in_header);
    assign want       = c_magic_idx ? i_cfg.magic_word[BYTE_W-1:0]
                                    : i_cfg.magic_word[MAGIC_W-1:BYTE_W];
    assign match_ok   = c_magic_ok && (g_shift[BYTE_W-1:0] == want);
    assign ext_dec    = c_ext_left - 1'b1;
    assign data_dec   = c_data_left - 1'b1;

    always_comb begin
        n_phase     = c_phase;
        n_hdr_cnt   = c_hdr_cnt;
        n_bit_cnt   = c_bit_cnt;
        n_shift     = c_shift;
        n_magic_idx = c_magic_idx;
        n_magic_ok  = c_magic_ok;
        n_ext_left  = c_ext_left;
        n_data_left = c_data_left;
        o_res_valid = 1'b0;
        o_res       = '{secret_byte: '0, result_kind: KIND_EXT_CHAR, last_byte: 1'b0};

        priority if (in_header) begin
            n_hdr_cnt = c_hdr_cnt + 1'b1;
            if (n_hdr_cnt >= i_cfg.header_bytes) begin
                n_phase = PH_MAGIC;
            end
        end else if (take_magic) begin
            n_phase   = PH_MAGIC;
            n_shift   = g_shift;
            n_bit_cnt = g_cnt;
            if (done8) begin
                n_shift    = '0;
                n_bit_cnt  = '0;
                n_magic_ok = match_ok;
                if (!c_magic_idx) begin
                    n_magic_idx = 1'b1;
                end else begin
                    n_magic_idx = 1'b0;
                    if (!match_ok) begin
                        n_phase     = PH_DONE;
                        o_res_valid = 1'b1;
                        o_res       = '{secret_byte: '0, result_kind: KIND_BAD_MAGIC,
                                        last_byte: 1'b1};
                    end else begin
                        n_phase = PH_EXTLEN;
                    end
                end
            end
        end else if (c_phase == PH_EXTLEN || c_phase == PH_FILELEN) begin
            n_shift   = g_shift;
            n_bit_cnt = g_cnt;
            if (done32) begin
                n_shift = '0;
                if (c_phase == PH_EXTLEN) begin
                    n_ext_left = g_shift;
                    n_phase    = (g_shift == '0) ? PH_FILELEN : PH_EXTDATA;
                end else begin
                    n_data_left = g_shift;
                    if (g_shift == '0) begin
                        n_phase     = PH_DONE;
                        o_res_valid = 1'b1;
                        o_res       = '{secret_byte: '0, result_kind: KIND_EMPTY,
                                        last_byte: 1'b1};
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
        end else if (c_phase == PH_EXTDATA || c_phase == PH_DATA) begin
            n_shift   = g_shift;
            n_bit_cnt = g_cnt;
            if (done8) begin
                n_shift     = '0;
                n_bit_cnt   = '0;
                o_res_valid = 1'b1;
                if (c_phase == PH_EXTDATA) begin
                    n_ext_left = ext_dec;
                    if (ext_dec == '0) begin
                        n_phase = PH_FILELEN;
                    end
                    o_res = '{secret_byte: g_shift[BYTE_W-1:0], result_kind: KIND_EXT_CHAR,
                              last_byte: 1'b0};
                end else begin
                    n_data_left = data_dec;
                    if (data_dec == '0) begin
                        n_phase = PH_DONE;
                    end
                    o_res = '{secret_byte: g_shift[BYTE_W-1:0], result_kind: KIND_DATA_BYTE,
                              last_byte: (data_dec == '0)};
                end
            end
        end else begin
            n_phase = c_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_magic_idx <= 1'b0;
            r_magic_ok  <= 1'b1;
            r_ext_left  <= '0;
            r_data_left <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_bit_cnt   <= n_bit_cnt;
            r_shift     <= n_shift;
            r_magic_idx <= n_magic_idx;
            r_magic_ok  <= n_magic_ok;
            r_ext_left  <= n_ext_left;
            r_data_left <= n_data_left;
        end
    end
endmodule

[sv/lsb_stego_extractor.sv]
// LSB stego extractor: accepted bytes pass the input register, then the result register.
// Throughput is one image byte per cycle while the result side takes requests.
// The input register, the parse step and the result register form the only path.
// Synchronous active-low reset restores the parse state and both config registers
// (header 54, magic "#&"); no result request is pending after reset.
// Depends on lse_pkg, lse_if, lse_in_stage and lse_parser.
module lsb_stego_extractor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  lse_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [lse_pkg::MAGIC_W-1:0] i_cfg_data,
    lse_in_if.sink                      i_in,
    lse_out_if.source                   o_out
);
    import lse_pkg::*;

    t_cfg    r_cfg;
    t_item   in_item;
    t_item   st_item;
    logic    st_valid;
    logic    proc_en;
    logic    res_valid;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign in_item = '{image_byte: i_in.image_byte, image_start: i_in.image_start};
    assign proc_en = st_valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{header_bytes: HEADER_RESET, magic_word: MAGIC_RESET};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEADER_BYTES: r_cfg.header_bytes <= i_cfg_data[BYTE_W-1:0];
                CFG_MAGIC_WORD:   r_cfg.magic_word   <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    lse_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (in_item),
        .o_ready (i_in.ready),
        .i_take  (proc_en),
        .o_valid (st_valid),
        .o_item  (st_item)
    );

    lse_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (proc_en),
        .i_item      (st_item),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_en) begin
            r_out_valid <= res_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_en && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.secret_byte = r_out.secret_byte;
    assign o_out.result_kind = r_out.result_kind;
    assign o_out.last_byte   = r_out.last_byte;

    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result request pending right after reset");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.result_kind == KIND_BAD_MAGIC || o_out.result_kind == KIND_EMPTY)
        |-> o_out.last_byte && (o_out.secret_byte == '0))
        else $error("status result without last flag or with nonzero byte");

    a_held_stage_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_valid && !proc_en |-> !i_in.ready)
        else $error("input accepted while the stage register is still held");

    a_ext_never_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.result_kind == KIND_EXT_CHAR) |-> !o_out.last_byte)
        else $error("extension character marked as last");
endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for lsb_stego_extractor: hides messages in image bytes, predicts
// the decoded characters and status results, and checks every result request in order.
// Depends on lse_pkg, lse_if and the lsb_stego_extractor RTL.
module testbench;
    import lse_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RAND_ITEMS   = 400;
    localparam logic [CNT_W-1:0] SIZE_BITS = CNT_W'(WORD_W);

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    t_cfg_idx cfg_idx;
    logic [MAGIC_W-1:0] cfg_data;

    lse_in_if  in_if ();
    lse_out_if out_if ();

    lsb_stego_extractor i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state and the register values it decodes with.
    t_cfg               cfg_mirror;
    t_phase             ph;
    logic [BYTE_W-1:0]  hdr_cnt;
    logic [CNT_W-1:0]   bit_cnt;
    logic [WORD_W-1:0]  shreg;
    logic               magic_second;
    logic               magic_good;
    logic [WORD_W-1:0]  ext_left;
    logic [WORD_W-1:0]  data_left;

    t_result decoded_q [$];
    t_result want_res;
    t_item   img_q [$];

    int unsigned errors;
    int unsigned cycle_cnt;
    int unsigned in_stalls;
    int unsigned items_sent;
    int unsigned live_items;
    int unsigned kind_cnt [4];
    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    int unsigned hold_left;
    logic        hold_start;

    function automatic void clear_parse();
        ph           = PH_HEADER;
        hdr_cnt      = '0;
        bit_cnt      = '0;
        shreg        = '0;
        magic_second = 1'b0;
        magic_good   = 1'b1;
        ext_left     = '0;
        data_left    = '0;
    endfunction

    function automatic logic shift_in(input logic bt, input logic [CNT_W-1:0] need);
        shreg   = {shreg[WORD_W-2:0], bt};
        bit_cnt = bit_cnt + 1'b1;
        if (bit_cnt == need) begin
            bit_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_decoded(input logic [BYTE_W-1:0] ch, input t_kind kind,
                                        input logic last);
        t_result r;
        r.secret_byte = ch;
        r.result_kind = kind;
        r.last_byte   = last;
        decoded_q.push_back(r);
        kind_cnt[kind]++;
    endfunction

    function automatic void decode_lsb(input logic [BYTE_W-1:0] b, input logic s);
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] want;
        if (s) clear_parse();
        if (ph != PH_DONE) live_items++;
        if (ph == PH_HEADER && hdr_cnt < cfg_mirror.header_bytes) begin
            hdr_cnt = hdr_cnt + 1'b1;
            if (hdr_cnt >= cfg_mirror.header_bytes) ph = PH_MAGIC;
        end else begin
            if (ph == PH_HEADER) ph = PH_MAGIC;
            case (ph)
                PH_MAGIC: begin
                    if (shift_in(b[0], CHAR_BITS)) begin
                        ch    = shreg[BYTE_W-1:0];
                        shreg = '0;
                        want  = magic_second ? cfg_mirror.magic_word[7:0]
                                             : cfg_mirror.magic_word[15:8];
                        if (ch != want) magic_good = 1'b0;
                        if (!magic_second) begin
                            magic_second = 1'b1;
                        end else begin
                            magic_second = 1'b0;
                            if (!magic_good) begin
                                ph = PH_DONE;
                                add_decoded('0, KIND_BAD_MAGIC, 1'b1);
                            end else begin
                                ph = PH_EXTLEN;
                            end
                        end
                    end
                end
                PH_EXTLEN: begin
                    if (shift_in(b[0], SIZE_BITS)) begin
                        ext_left = shreg;
                        shreg    = '0;
                        if (ext_left == 0) ph = PH_FILELEN;
                        else ph = PH_EXTDATA;
                    end
                end
                PH_EXTDATA: begin
                    if (shift_in(b[0], CHAR_BITS)) begin
                        ch       = shreg[BYTE_W-1:0];
                        shreg    = '0;
                        ext_left = ext_left - 1'b1;
                        if (ext_left == 0) ph = PH_FILELEN;
                        add_decoded(ch, KIND_EXT_CHAR, 1'b0);
                    end
                end
                PH_FILELEN: begin
                    if (shift_in(b[0], SIZE_BITS)) begin
                        data_left = shreg;
                        shreg     = '0;
                        if (data_left == 0) begin
                            ph = PH_DONE;
                            add_decoded('0, KIND_EMPTY, 1'b1);
                        end else begin
                            ph = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    if (shift_in(b[0], CHAR_BITS)) begin
                        ch        = shreg[BYTE_W-1:0];
                        shreg     = '0;
                        data_left = data_left - 1'b1;
                        if (data_left == 0) ph = PH_DONE;
                        add_decoded(ch, KIND_DATA_BYTE, data_left == 0);
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void add_filler(input int unsigned n);
        t_item it;
        repeat (n) begin
            it.image_byte  = BYTE_W'($urandom);
            it.image_start = 1'b0;
            img_q.push_back(it);
        end
    endfunction

    function automatic void begin_image();
        img_q.delete();
        add_filler(cfg_mirror.header_bytes);
    endfunction

    function automatic void hide_bits(input logic [WORD_W-1:0] val, input int nbits);
        t_item it;
        for (int k = nbits - 1; k >= 0; k--) begin
            it.image_byte    = BYTE_W'($urandom);
            it.image_byte[0] = val[k];
            it.image_start   = 1'b0;
            img_q.push_back(it);
        end
    endfunction

    function automatic void hide_message(input logic [MAGIC_W-1:0] mgc,
                                         input logic [WORD_W-1:0] ext_len, input int ext_n,
                                         input logic [WORD_W-1:0] file_len, input int data_n);
        hide_bits(mgc, MAGIC_W);
        hide_bits(ext_len, WORD_W);
        repeat (ext_n) hide_bits($urandom, BYTE_W);
        hide_bits(file_len, WORD_W);
        repeat (data_n) hide_bits($urandom, BYTE_W);
    endfunction

    task automatic send_byte(input t_item it);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.image_byte  <= it.image_byte;
        in_if.image_start <= it.image_start;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        items_sent++;
        decode_lsb(it.image_byte, it.image_start);
    endtask

    task automatic send_image(input logic with_start);
        if (with_start) img_q[0].image_start = 1'b1;
        foreach (img_q[k]) send_byte(img_q[k]);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [MAGIC_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HEADER_BYTES) cfg_mirror.header_bytes = val[BYTE_W-1:0];
        else cfg_mirror.magic_word = val;
    endtask

    task automatic write_header(input logic [BYTE_W-1:0] n);
        write_reg(CFG_HEADER_BYTES, {BYTE_W'($urandom), n});
    endtask

    task automatic set_idling(input int unsigned tx, input int unsigned rx);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
    endtask

    task automatic test_no_start();
        begin_image();
        hide_message(cfg_mirror.magic_word, 1, 1, 1, 1);
        send_image(1'b0);
        settle();
    endtask

    task automatic test_config_extremes();
        write_header(8'd0);
        write_reg(CFG_MAGIC_WORD, 16'h0000);
        begin_image();
        hide_message(cfg_mirror.magic_word, 0, 0, 2, 2);
        send_image(1'b1);
        settle();
        write_header(8'd255);
        write_reg(CFG_MAGIC_WORD, 16'hFFFF);
        begin_image();
        hide_message(cfg_mirror.magic_word, 1, 1, 1, 1);
        send_image(1'b1);
        settle();
        write_header(8'd3);
        write_reg(CFG_MAGIC_WORD, MAGIC_RESET);
    endtask

    task automatic test_bad_magic();
        begin_image();
        hide_message(cfg_mirror.magic_word ^ 16'h0100, 1, 1, 1, 1);
        send_image(1'b1);
        begin_image();
        hide_message(cfg_mirror.magic_word ^ 16'h0080, 1, 1, 1, 1);
        send_image(1'b1);
        settle();
    endtask

    task automatic test_empty_secret();
        begin_image();
        hide_message(cfg_mirror.magic_word, 1, 1, 0, 0);
        add_filler(12);
        send_image(1'b1);
        settle();
    endtask

    task automatic test_header_change();
        // The skip count has already passed the new, shorter header.
        write_header(8'd54);
        img_q.delete();
        add_filler(10);
        send_image(1'b1);
        settle();
        write_header(8'd4);
        img_q.delete();
        hide_message(cfg_mirror.magic_word, 0, 0, 2, 2);
        send_image(1'b0);
        settle();
        // A longer header keeps the skip going.
        write_header(8'd20);
        img_q.delete();
        add_filler(3);
        send_image(1'b1);
        settle();
        write_header(8'd6);
        img_q.delete();
        add_filler(3);
        hide_message(cfg_mirror.magic_word, 1, 1, 2, 2);
        send_image(1'b0);
        settle();
    endtask

    task automatic test_long_lengths();
        begin_image();
        hide_bits(cfg_mirror.magic_word, MAGIC_W);
        hide_bits(32'hFFFF_FFFF, WORD_W);
        repeat (2) hide_bits($urandom, BYTE_W);
        send_image(1'b1);
        begin_image();
        hide_message(cfg_mirror.magic_word, 0, 0, 32'h8000_0001, 3);
        send_image(1'b1);
        begin_image();
        hide_message(cfg_mirror.magic_word, 32'h0000_0001, 1, 1, 1);
        send_image(1'b1);
        settle();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        hold_start = 1'b1;
        begin_image();
        hide_message(cfg_mirror.magic_word, 1, 1, 6, 6);
        send_image(1'b1);
        settle();
    endtask

    task automatic send_random_image();
        int unsigned pick;
        int unsigned ext_n;
        int unsigned data_n;
        int unsigned cut;
        pick   = $urandom_range(99);
        ext_n  = $urandom_range(0, 3);
        data_n = $urandom_range(1, 12);
        begin_image();
        if (pick < 60) begin
            hide_message(cfg_mirror.magic_word, ext_n, ext_n, data_n, data_n);
            add_filler($urandom_range(0, 3));
        end else if (pick < 70) begin
            hide_message(cfg_mirror.magic_word, ext_n, ext_n, data_n, data_n);
            cut = $urandom_range(1, img_q.size() - 1);
            while (img_q.size() > cut) void'(img_q.pop_back());
        end else if (pick < 78) begin
            hide_message(cfg_mirror.magic_word ^ (16'h1 << $urandom_range(15)), 0, 0, 1, 1);
        end else if (pick < 86) begin
            hide_message(cfg_mirror.magic_word, ext_n, ext_n, 0, 0);
        end else if (pick < 93) begin
            hide_message(cfg_mirror.magic_word, ext_n, ext_n, data_n, data_n);
            img_q[$urandom_range(1, img_q.size() - 1)].image_start = 1'b1;
        end else begin
            add_filler($urandom_range(10, 60));
        end
        send_image(1'b1);
    endtask

    task automatic test_random_images();
        int unsigned goal;
        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: set_idling(0, 0);
                1: set_idling(71, 0);
                2: set_idling(0, 71);
                default: set_idling(36, 36);
            endcase
            write_header(BYTE_W'($urandom_range(0, 10)));
            write_reg(CFG_MAGIC_WORD, MAGIC_W'($urandom));
            goal = live_items + RAND_ITEMS / 4;
            while (live_items < goal) send_random_image();
        end
        set_idling(0, 0);
        settle();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (hold_start) begin
            hold_start = 1'b0;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result: secret_byte %0h, result_kind %0d, last_byte %0b",
                       out_if.secret_byte, out_if.result_kind, out_if.last_byte);
                errors++;
            end else begin
                want_res = decoded_q.pop_front();
                if (out_if.secret_byte !== want_res.secret_byte) begin
                    $error("secret_byte: expected %0h, got %0h",
                           want_res.secret_byte, out_if.secret_byte);
                    errors++;
                end
                if (out_if.result_kind !== want_res.result_kind) begin
                    $error("result_kind: expected %0d, got %0d",
                           want_res.result_kind, out_if.result_kind);
                    errors++;
                end
                if (out_if.last_byte !== want_res.last_byte) begin
                    $error("last_byte: expected %0b, got %0b",
                           want_res.last_byte, out_if.last_byte);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (in_if.valid === 1'b1 && in_if.ready === 1'b0) in_stalls++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycle_cnt);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_HEADER_BYTES;
        cfg_data          = '0;
        in_if.valid       = 1'b0;
        in_if.image_byte  = '0;
        in_if.image_start = 1'b0;
        out_if.ready      = 1'b0;
        hold_start        = 1'b0;
        errors            = 0;
        cycle_cnt         = 0;
        in_stalls         = 0;
        items_sent        = 0;
        live_items        = 0;
        foreach (kind_cnt[k]) kind_cnt[k] = 0;
        set_idling(0, 0);
        cfg_mirror.header_bytes = HEADER_RESET;
        cfg_mirror.magic_word   = MAGIC_RESET;
        clear_parse();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_no_start();
        test_config_extremes();
        test_bad_magic();
        test_empty_secret();
        test_header_change();
        test_long_lengths();
        test_backpressure();
        test_random_images();

        $display("Sent %0d image bytes (%0d parsed) in %0d cycles, input stalled %0d cycles.",
                 items_sent, live_items, cycle_cnt, in_stalls);
        $display("Checked %0d extension chars, %0d data bytes, %0d bad magic, %0d empty.",
                 kind_cnt[KIND_EXT_CHAR], kind_cnt[KIND_DATA_BYTE],
                 kind_cnt[KIND_BAD_MAGIC], kind_cnt[KIND_EMPTY]);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[lsb_stego_extractor.f]
sv/lse_pkg.sv
sv/lse_if.sv
sv/lse_in_stage.sv
sv/lse_parser.sv
sv/lsb_stego_extractor.sv
verif/testbench.sv
